// ===== sv/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the triangle scanline span unit.
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int XW = 14;
	localparam int YW = 10;
	localparam int CW = 12;

	typedef struct packed {
		logic [XW-1:0] ax;
		logic [YW-1:0] ay;
		logic [XW-1:0] bx;
		logic [YW-1:0] by;
		logic [XW-1:0] cx;
		logic [YW-1:0] cy;
	} tri_in_t;

	typedef struct packed {
		logic [5:0]          row;
		logic signed [CW-1:0] span_start;
		logic signed [CW-1:0] span_end;
		logic                last_span;
	} span_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture and sort triangle
		logic div_start; // start division for selected edge
		logic [1:0] div_sel; // 0: A-C, 1: A-B, 2: B-C
		logic div_step;  // one restoring-division step
		logic div_store; // store quotient into selected slope
		logic emit;      // latch span into output register
		logic next_row;  // advance row counter
	} tss_cmd_t;

	typedef struct packed {
		logic flat;      // no spans at all
		logic div_done;
		logic row_done;  // current row is past the last row
		logic last_row;  // current row is the final one
	} tss_sts_t;

	localparam logic [1:0] EDGE_AC = 2'd0;
	localparam logic [1:0] EDGE_AB = 2'd1;
	localparam logic [1:0] EDGE_BC = 2'd2;

endpackage

// ===== sv/tss_datapath.sv =====
// ----------------------------------------------------------------------------
// tss_datapath
// Vertex sort, shared serial divider, edge evaluation and span output.
// ----------------------------------------------------------------------------
module tss_datapath import tss_pkg::*; #(
	parameter int TILE_ROWS = 64,
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  logic      clk,
	input  tri_in_t   tri_in,
	input  tss_cmd_t  cmd,
	output tss_sts_t  sts,
	output span_out_t span_q
);
	localparam int NW  = XW + SLOPE_FRAC_BITS;   // dividend magnitude width
	localparam int SW  = NW + 1;                 // signed slope width
	localparam int FB  = 4 + SLOPE_FRAC_BITS;    // fraction bits of edge value
	localparam int VW  = SW + YW + 3;            // edge accumulator width
	localparam int CTW = $clog2(NW + 1);

	// sorted vertices
	logic [XW-1:0] axq, bxq, cxq;
	logic [YW-1:0] ayq, byq, cyq;
	logic          s_q;
	logic signed [SW-1:0] sac_q, sab_q, sbc_q;
	logic [6:0] row_q;

	// sorting network
	logic [XW-1:0] x0, x1, x2, x3, x4, x5, x6, x7, x8;
	logic [YW-1:0] y0, y1, y2, y3, y4, y5, y6, y7, y8;
	always_comb begin
		{x0, y0, x1, y1} = {tri_in.ax, tri_in.ay, tri_in.bx, tri_in.by};
		if (y0 > y1 || (y0 == y1 && x0 > x1)) {x0, y0, x1, y1} = {x1, y1, x0, y0};
		{x2, y2} = {tri_in.cx, tri_in.cy};
		{x3, y3, x4, y4} = {x0, y0, x2, y2};
		if (y3 > y4 || (y3 == y4 && x3 > x4)) {x3, y3, x4, y4} = {x4, y4, x3, y3};
		{x5, y5, x6, y6} = {x1, y1, x4, y4};
		if (y5 > y6 || (y5 == y6 && x5 > x6)) {x5, y5, x6, y6} = {x6, y6, x5, y5};
		{x7, y7, x8, y8} = {x3, y3, x5, y5};
	end

	// orientation test on sorted vertices
	logic signed [YW+1:0] dyab, dyac;
	logic signed [XW+1:0] dxac, dxab;
	logic signed [XW+YW+3:0] pl, pr;
	always_comb begin
		dyab = $signed({2'b0, y8}) - $signed({2'b0, y7});
		dyac = $signed({2'b0, y6}) - $signed({2'b0, y7});
		dxac = $signed({2'b0, x6}) - $signed({2'b0, x7});
		dxab = $signed({2'b0, x8}) - $signed({2'b0, x7});
		pl = (XW+YW+4)'(dyab) * (XW+YW+4)'(dxac);
		pr = (XW+YW+4)'(dxab) * (XW+YW+4)'(dyac);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			axq <= x7; ayq <= y7;
			bxq <= x8; byq <= y8;
			cxq <= x6; cyq <= y6;
			s_q <= pl < pr;
			row_q <= {1'b0, y7[YW-1:4]};
		end else if (cmd.next_row) begin
			row_q <= row_q + 7'd1;
		end
	end

	// serial restoring divider
	logic [XW-1:0] dsel_x0, dsel_x1;
	logic [YW-1:0] dsel_y0, dsel_y1;
	logic [NW-1:0] num_q, quo_q;
	logic [YW:0]   rem_q;
	logic [YW-1:0] den_q;
	logic          neg_q;
	logic [CTW-1:0] cnt_q;
	logic [YW:0]   trial;
	logic [XW:0]   dxd;
	always_comb begin
		unique case (cmd.div_sel)
			EDGE_AB: begin dsel_x0 = axq; dsel_y0 = ayq; dsel_x1 = bxq; dsel_y1 = byq; end
			EDGE_BC: begin dsel_x0 = bxq; dsel_y0 = byq; dsel_x1 = cxq; dsel_y1 = cyq; end
			default: begin dsel_x0 = axq; dsel_y0 = ayq; dsel_x1 = cxq; dsel_y1 = cyq; end
		endcase
		dxd   = {1'b0, dsel_x1} - {1'b0, dsel_x0};
		trial = {rem_q[YW-1:0], num_q[NW-1]};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= dxd[XW];
			num_q <= {(dxd[XW] ? (XW)'(-dxd) : dxd[XW-1:0]), {SLOPE_FRAC_BITS{1'b0}}};
			den_q <= dsel_y1 - dsel_y0;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= CTW'(NW);
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			cnt_q <= cnt_q - 1'b1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// slope registers; zero height edge keeps slope zero
	logic signed [SW-1:0] qs;
	always_comb qs = (den_q == '0) ? '0 :
		(neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q}));
	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			unique case (cmd.div_sel)
				EDGE_AB: sab_q <= qs;
				EDGE_BC: sbc_q <= qs;
				default: sac_q <= qs;
			endcase
		end
	end

	// edge evaluation for the current row
	logic lower;
	logic signed [VW-1:0] v1, v2;
	logic signed [YW+3:0] d1, d2;
	logic signed [CW-1:0] e1, e2;
	always_comb lower = row_q >= {1'b0, byq[YW-1:4]};

	function automatic logic signed [CW-1:0] col(input logic signed [VW-1:0] v);
		logic [VW-1:0] mag;
		logic [VW-1:0] p;
		begin
			mag = v[VW-1] ? VW'(-v) : VW'(v);
			p = mag >> FB;
			if (v[VW-1])
				col = (p > VW'(2048)) ? -CW'(2048) : -$signed(CW'(p));
			else
				col = (p > VW'(2047)) ? CW'(2047) : $signed(CW'(p));
		end
	endfunction

	always_comb begin
		d1 = $signed({3'b0, row_q, 4'b0} - {4'b0, ayq});
		d2 = $signed({3'b0, row_q, 4'b0} - {4'b0, (lower ? byq : ayq)});
		v1 = $signed(VW'({axq, {SLOPE_FRAC_BITS{1'b0}}})) + VW'(sac_q) * VW'(d1);
		v2 = $signed(VW'({(lower ? bxq : axq), {SLOPE_FRAC_BITS{1'b0}}}))
			+ VW'(lower ? sbc_q : sab_q) * VW'(d2);
		e1 = col(v1);
		e2 = col(v2);
	end

	// status
	logic [6:0] rend;
	always_comb begin
		rend = ({1'b0, cyq[YW-1:4]} < 7'(TILE_ROWS)) ? {1'b0, cyq[YW-1:4]} : 7'(TILE_ROWS);
		sts.flat     = (y7 == y6) || (y7[YW-1:4] == y6[YW-1:4]) ||
			({1'b0, y7[YW-1:4]} >= 7'(TILE_ROWS));
		sts.div_done = (cnt_q == '0);
		sts.row_done = row_q >= rend;
		sts.last_row = (row_q + 7'd1) >= rend;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			span_q.row        <= row_q[5:0];
			span_q.span_start <= s_q ? e1 : e2;
			span_q.span_end   <= s_q ? e2 : e1;
			span_q.last_span  <= sts.last_row;
		end
	end

endmodule

// ===== sv/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: load, three slope divisions, then one span beat per row.
// ----------------------------------------------------------------------------
module tss_ctrl import tss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  tss_sts_t sts,
	output tss_cmd_t cmd,
	output logic     out_valid,
	input  logic     out_stall
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DSTA = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_ROW  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [1:0] sel_q;
	logic ovalid_q;
	logic done_q;

	assign out_valid = ovalid_q;
	// accept input only when idle and output is free
	assign in_stall = !(state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.div_sel = sel_q;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_DSTA: cmd.div_start = 1'b1;
			ST_DIV:  begin
				cmd.div_step  = !sts.div_done;
				cmd.div_store = sts.div_done;
			end
			ST_ROW:  begin
				cmd.emit     = !sts.row_done && (!ovalid_q || !out_stall);
				cmd.next_row = cmd.emit;
			end
			ST_OUT:  ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sel_q    <= EDGE_AC;
			ovalid_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (cmd.emit) ovalid_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					sel_q   <= EDGE_AC;
					state_q <= sts.flat ? ST_IDLE : ST_DSTA;
				end
				ST_DSTA: state_q <= ST_DIV;
				ST_DIV:  if (sts.div_done) begin
					if (sel_q == EDGE_BC) state_q <= ST_ROW;
					else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_DSTA;
					end
				end
				ST_ROW:  if (cmd.emit && sts.last_row) state_q <= ST_OUT;
				ST_OUT:  if (!ovalid_q || !out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			done_q <= 1'b0;
		end
	end

	// output stays valid while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && out_stall |=> ovalid_q)
		else $error("span beat dropped while stalled");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input accepted while busy");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == ST_ROW)
		else $error("emit outside row state");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q == 1'b0)
		else $error("done flag stuck");

endmodule

// ===== sv/triangle_scanline_spans_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_scanline_spans_unit
// Scanline fill of one triangle: sorted vertices, three serial slope
// divisions, then one span beat per covered row.
// Sequence: load, then per edge a start state, the serial division steps and a
// store, then the first span; one span per cycle after that while out_stall is low.
// Input: a new triangle is taken only once all spans of the last one are out.
// Flat triangles are taken and give no beat.
// Reset: arst_n clears the sequencer and output valid; data registers are not reset.
// ----------------------------------------------------------------------------
module triangle_scanline_spans_unit import tss_pkg::*; #(
	parameter int TILE_ROWS = 64,
	parameter int SLOPE_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tri_in_t   in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output span_out_t out_data
);
	tss_cmd_t cmd;
	tss_sts_t sts;

	tss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd), .out_valid(out_valid), .out_stall(out_stall)
	);

	tss_datapath #(.TILE_ROWS(TILE_ROWS), .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)) u_dp (
		.clk(clk), .tri_in(in_data), .cmd(cmd), .sts(sts), .span_q(out_data)
	);

endmodule

// ===== verif/triangle_scanline_spans_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_scanline_spans_unit_test
// Drives triangles into the span unit and checks each span beat, field by
// field, against a behavioral scanline predictor. A short table of directed
// triangles comes first, then random triangles under three idling patterns,
// one long output hold-off, with a full drain after each part.
// ----------------------------------------------------------------------------
module triangle_scanline_spans_unit_test;
	import tss_pkg::*;

	localparam int TILE_ROWS = 64;
	localparam int SFB = 16;
	localparam int LIMIT = 2000000;
	localparam int N_RANDOM = 260;

	typedef struct packed {
		logic          check_row0;
		int            want_beats; // -1: not typed in
		tri_in_t       tri_item;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	tri_in_t   in_data;
	logic      out_valid;
	logic      out_stall;
	span_out_t out_data;

	span_out_t span_q[$];
	int        sender_idle_pct;
	int        recv_idle_pct;
	bit        hold_off;
	int        mismatches;
	int        beats_seen;
	int        tris_sent;
	longint    cycles;

	triangle_scanline_spans_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic longint slope_of(longint dx, longint dy);
		longint q;
		if (dy <= 0)
			return 0;
		q = ((dx < 0 ? -dx : dx) << SFB) / dy;
		return dx < 0 ? -q : q;
	endfunction

	function automatic logic signed [CW-1:0] column_at(longint x0, longint y0,
			longint slope, longint r);
		longint v;
		longint p;
		v = (x0 << SFB) + slope * (r * 16 - y0);
		p = v < 0 ? -((-v) >>> (4 + SFB)) : (v >>> (4 + SFB));
		if (p < -2048) p = -2048;
		if (p > 2047) p = 2047;
		return p[CW-1:0];
	endfunction

	// scanline predictor: pushes the spans one triangle gives
	task automatic predict_spans(input tri_in_t t);
		longint vx[3];
		longint vy[3];
		longint tx, ty, sac, sab, sbc, r, e1, e2;
		bit     lhs;
		int     i, j, first;
		span_out_t s;
		vx[0] = t.ax; vy[0] = t.ay;
		vx[1] = t.bx; vy[1] = t.by;
		vx[2] = t.cx; vy[2] = t.cy;
		// sort by y then x: pairs (0,1), (0,2), (1,2)
		for (int k = 0; k < 3; k++) begin
			i = (k == 2) ? 1 : 0;
			j = (k == 0) ? 1 : 2;
			if (vy[i] > vy[j] || (vy[i] == vy[j] && vx[i] > vx[j])) begin
				tx = vx[i]; vx[i] = vx[j]; vx[j] = tx;
				ty = vy[i]; vy[i] = vy[j]; vy[j] = ty;
			end
		end
		if (vy[0] == vy[2])
			return;
		lhs = (vy[1] - vy[0]) * (vx[2] - vx[0]) < (vx[1] - vx[0]) * (vy[2] - vy[0]);
		sac = slope_of(vx[2] - vx[0], vy[2] - vy[0]);
		sab = slope_of(vx[1] - vx[0], vy[1] - vy[0]);
		sbc = slope_of(vx[2] - vx[1], vy[2] - vy[1]);
		first = span_q.size();
		for (r = vy[0] >> 4; r < (vy[2] >> 4) && r < TILE_ROWS; r++) begin
			e1 = column_at(vx[0], vy[0], sac, r);
			if (r < (vy[1] >> 4))
				e2 = column_at(vx[0], vy[0], sab, r);
			else
				e2 = column_at(vx[1], vy[1], sbc, r);
			s.row = r[5:0];
			s.span_start = lhs ? e1[CW-1:0] : e2[CW-1:0];
			s.span_end = lhs ? e2[CW-1:0] : e1[CW-1:0];
			s.last_span = 1'b0;
			span_q.push_back(s);
		end
		if (span_q.size() > first)
			span_q[$].last_span = 1'b1;
	endtask

	function automatic tri_in_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy);
		tri_in_t t;
		t.ax = XW'(ax); t.ay = YW'(ay);
		t.bx = XW'(bx); t.by = YW'(by);
		t.cx = XW'(cx); t.cy = YW'(cy);
		return t;
	endfunction

	function automatic tri_in_t random_tri();
		tri_in_t t;
		int base;
		t = '0;
		t.ax = XW'($urandom); t.bx = XW'($urandom); t.cx = XW'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				// any bits at all; y may fall in any row of the tile
				t.ay = YW'($urandom); t.by = YW'($urandom); t.cy = YW'($urandom);
			end
			1: begin
				// flat or within one row
				base = $urandom_range(0, 1023);
				t.ay = YW'(base); t.by = YW'(base);
				t.cy = YW'((base & 'h3F0) | $urandom_range(0, 15));
			end
			default: begin
				// small triangle in the tile
				base = $urandom_range(0, 900);
				t.ay = YW'(base + $urandom_range(0, 120));
				t.by = YW'(base + $urandom_range(0, 120));
				t.cy = YW'(base + $urandom_range(0, 120));
				t.ax = XW'($urandom_range(0, 2000) + ($urandom_range(0, 1) ? 0 : 14000));
			end
		endcase
		return t;
	endfunction

	// send one triangle beat, honoring stall
	task automatic send_tri(input tri_in_t t);
		while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
			@(negedge clk);
		in_data = t;
		in_valid = 1'b1;
		predict_spans(t);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tris_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// receiver stall, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
	end

	// span checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (span_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected span beat %p", out_data);
			end else begin
				if (out_data.row !== span_q[0].row
						|| out_data.span_start !== span_q[0].span_start
						|| out_data.span_end !== span_q[0].span_end
						|| out_data.last_span !== span_q[0].last_span) begin
					mismatches++;
					if (mismatches <= 10)
						$display("span mismatch: expected %p got %p", span_q[0], out_data);
				end
				void'(span_q.pop_front());
			end
		end
	end

	task automatic drain();
		while (span_q.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	stim_row_t dir_tab[$];

	initial begin
		int before_cnt;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		hold_off = 1'b0;
		sender_idle_pct = 0;
		recv_idle_pct = 0;
		mismatches = 0;
		beats_seen = 0;
		tris_sent = 0;
		cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed table: flat, one-row, extremes, both edge orders
		dir_tab.push_back('{1'b0, 0, mk_tri(0, 0, 0, 0, 0, 0)});
		dir_tab.push_back('{1'b0, 0, mk_tri(16383, 1023, 16383, 1023, 16383, 1023)});
		dir_tab.push_back('{1'b0, 0, mk_tri(10, 5, 200, 5, 100, 5)});
		dir_tab.push_back('{1'b0, 0, mk_tri(10, 17, 200, 20, 100, 31)});
		dir_tab.push_back('{1'b0, -1, mk_tri(0, 0, 16383, 1023, 0, 1023)});
		dir_tab.push_back('{1'b0, -1, mk_tri(16383, 0, 0, 1023, 16383, 1023)});
		dir_tab.push_back('{1'b0, -1, mk_tri(0, 0, 16383, 500, 0, 1023)});
		dir_tab.push_back('{1'b0, -1, mk_tri(16383, 0, 0, 500, 16383, 1023)});
		dir_tab.push_back('{1'b0, -1, mk_tri(160, 160, 320, 320, 0, 480)});
		dir_tab.push_back('{1'b0, -1, mk_tri(0, 480, 320, 320, 160, 160)});
		dir_tab.push_back('{1'b0, -1, mk_tri(100, 8, 300, 8, 200, 200)});
		dir_tab.push_back('{1'b0, -1, mk_tri(100, 8, 200, 200, 300, 200)});
		dir_tab.push_back('{1'b0, -1, mk_tri(0, 15, 16383, 16, 8000, 1000)});
		dir_tab.push_back('{1'b0, -1, mk_tri(16383, 1008, 0, 1000, 100, 1023)});
		dir_tab.push_back('{1'b0, -1, mk_tri(5000, 3, 5000, 90, 5000, 300)});
		dir_tab.push_back('{1'b0, -1, mk_tri(12345, 999, 1, 2, 6000, 512)});
		foreach (dir_tab[k]) begin
			before_cnt = span_q.size();
			send_tri(dir_tab[k].tri_item);
			if (dir_tab[k].want_beats >= 0 && span_q.size() - before_cnt != dir_tab[k].want_beats) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: expected %0d spans, got %0d", k,
						dir_tab[k].want_beats, span_q.size() - before_cnt);
			end
		end
		drain();

		// random, three idling patterns
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 77 : 0;
			recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 13 : 0;
			for (int k = 0; k < N_RANDOM / 3; k++)
				send_tri(random_tri());
			// sender pauses until every span is back
			drain();
		end

		// long output hold-off while triangles keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int k = 0; k < 12; k++)
				send_tri(mk_tri($urandom_range(0, 16383), $urandom_range(0, 100),
					$urandom_range(0, 16383), $urandom_range(100, 600),
					$urandom_range(0, 16383), $urandom_range(600, 1023)));
		join
		drain();

		$display("%0d triangles, %0d span beats: flat, partial-tile, saturated and random cases",
			tris_sent, beats_seen);
		if (mismatches == 0 && span_q.size() == 0)
			$display("Regression PASS");
		else begin
			$display("%0d mismatches, %0d spans left over", mismatches, span_q.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
